@@ rtl/core/rtm_pkg.sv @@
// ----------------------------------------------------------------------------
// rtm_pkg: shared constants and types for the radix tree map
// Kinds, default geometry and the stack/sequencer control record.
// ----------------------------------------------------------------------------
package rtm_pkg;

    localparam int LEVELS_DEF     = 4;
    localparam int SLOT_BITS_DEF  = 4;
    localparam int NODE_COUNT_DEF = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KIND_W    = 2;
    localparam int KEY_W     = 16;
    localparam int IN_VAL_W  = 32;
    localparam int OUT_VAL_W = 32;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;
    // unused code, handled as a lookup
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

    // free-stack request from the sequencer
    typedef struct packed {
        logic pop;
        logic push;
    } stk_req_t;

endpackage

@@ rtl/core/rtm_free_stack.sv @@
// ----------------------------------------------------------------------------
// rtm_free_stack: pool of free node numbers
// Stack memory with a count; unwritten entries read as their reset contents
// (node N-1-i at position i), tracked by a low-water mark of the count.
// ----------------------------------------------------------------------------
module rtm_free_stack #(
    parameter int NODE_COUNT = rtm_pkg::NODE_COUNT_DEF,
    localparam int NW = $clog2(NODE_COUNT),
    localparam int CW = NW + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rtm_pkg::stk_req_t req,
    input  logic [NW-1:0]    push_node,
    output logic [CW-1:0]    count,
    output logic [NW-1:0]    top_node
);
    logic [NW-1:0] mem [NODE_COUNT];
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lw_reg, lw_next;   // positions below lw never written
    logic [NW-1:0] rd_reg;
    logic          rd_written_reg;
    logic [CW-1:0] rd_pos_reg;
    logic [CW-1:0] pos_rd;

    assign count = count_reg;

    // count and low-water mark
    always_comb begin
        count_next = count_reg;
        lw_next    = lw_reg;
        if (req.pop) begin
            count_next = count_reg - CW'(1);
            if (count_next < lw_reg) begin
                lw_next = count_next;
            end
        end else if (req.push) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(NODE_COUNT - 1);
            lw_reg    <= CW'(NODE_COUNT - 1);
        end else begin
            count_reg <= count_next;
            lw_reg    <= lw_next;
        end
    end

    // registered read of the next top
    assign pos_rd = count_next - CW'(1);
    always_ff @(posedge aclk) begin
        if (req.push) begin
            mem[count_reg[NW-1:0]] <= push_node;
        end
        rd_reg         <= mem[pos_rd[NW-1:0]];
        rd_written_reg <= (pos_rd >= lw_next);
        rd_pos_reg     <= pos_rd;
    end

    assign top_node = rd_written_reg ? rd_reg
                    : NW'(CW'(NODE_COUNT - 1) - rd_pos_reg);
endmodule

@@ rtl/core/rtm_engine.sv @@
// ----------------------------------------------------------------------------
// rtm_engine: tree walk sequencer
// Walks the key one level at a time over the slot memory, one read or
// write per cycle, and manages fill counts, parent links and node clears.
// ----------------------------------------------------------------------------
module rtm_engine #(
    parameter int LEVELS     = rtm_pkg::LEVELS_DEF,
    parameter int SLOT_BITS  = rtm_pkg::SLOT_BITS_DEF,
    parameter int NODE_COUNT = rtm_pkg::NODE_COUNT_DEF,
    parameter int VALUE_BITS = rtm_pkg::VALUE_BITS_DEF,
    localparam int NW = $clog2(NODE_COUNT),
    localparam int CW = NW + 1,
    localparam int AW = NW + SLOT_BITS,
    localparam int LW = $clog2(LEVELS + 1),
    localparam int FW = SLOT_BITS + 1,
    localparam int DEPTH = NODE_COUNT << SLOT_BITS,
    localparam int KX = LEVELS * SLOT_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rtm_pkg::KIND_W-1:0]    kind,
    input  logic [rtm_pkg::KEY_W-1:0]     key,
    input  logic [rtm_pkg::IN_VAL_W-1:0]  new_value,
    output logic                          busy,
    output logic                          done,
    output logic [rtm_pkg::OUT_VAL_W-1:0] old_value,
    output logic                          no_room
);
    localparam int SW = 4;
    localparam logic [SW-1:0] ST_IDLE  = 4'd0;
    localparam logic [SW-1:0] ST_CLR   = 4'd1;
    localparam logic [SW-1:0] ST_RD    = 4'd2;
    localparam logic [SW-1:0] ST_WAIT  = 4'd3;
    localparam logic [SW-1:0] ST_CHK   = 4'd4;
    localparam logic [SW-1:0] ST_NEW   = 4'd5;
    localparam logic [SW-1:0] ST_WIPE  = 4'd6;
    localparam logic [SW-1:0] ST_LEAF  = 4'd7;
    localparam logic [SW-1:0] ST_PRUNE = 4'd8;
    localparam logic [SW-1:0] ST_DONE  = 4'd9;
    localparam logic [SW-1:0] ST_PLINK = 4'd10;
    localparam logic [SW-1:0] ST_PFILL = 4'd11;

    logic [SW-1:0] st_reg, st_next_s;

    // slot memory, read data registered
    logic [VALUE_BITS-1:0] slots [DEPTH];
    logic [AW-1:0]         rd_addr, wr_addr;
    logic                  wr_en;
    logic [VALUE_BITS-1:0] wr_data, rd_data;
    logic [NW-1:0]         fill_node;
    logic                  clr_done_reg;
    logic [AW-1:0]         clr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slots[wr_addr] <= wr_data;
        end
        rd_data <= slots[rd_addr];
    end

    // per-node fill counts and parent links
    logic [FW-1:0] fill [NODE_COUNT];
    logic [AW-1:0] plink [NODE_COUNT];
    logic          fill_we, link_we;
    logic [NW-1:0] fill_wa, link_wa;
    logic [FW-1:0] fill_wd;
    logic [AW-1:0] link_wd;
    logic [FW-1:0] fill_rd;
    logic [AW-1:0] link_rd;

    // free stack
    rtm_pkg::stk_req_t sreq;
    logic [CW-1:0]     fcount;
    logic [NW-1:0]     ftop, push_node;
    rtm_free_stack #(.NODE_COUNT(NODE_COUNT)) u_stack (
        .aclk(aclk), .aresetn(aresetn), .req(sreq), .push_node(push_node),
        .count(fcount), .top_node(ftop)
    );

    // item registers
    logic [KX-1:0]         key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  ins_reg, ers_reg, alloc_reg;
    logic [LW-1:0]         lv_reg;
    logic [NW-1:0]         node_reg, fresh_reg;
    logic [SLOT_BITS-1:0]  wipe_reg;
    logic [VALUE_BITS-1:0] old_reg;
    logic                  room_reg;
    logic [KX-1:0]         key_x;
    logic [SLOT_BITS-1:0]  dig;
    logic [AW-1:0]         cur_addr;
    logic                  leaf_lv;

    // fill counts and links, read data registered
    always_ff @(posedge aclk) begin
        if (fill_we) fill[fill_wa] <= fill_wd;
        if (link_we) plink[link_wa] <= link_wd;
        fill_rd <= fill[fill_node];
        link_rd <= plink[node_reg];
    end

    assign key_x    = KX'(key_reg);
    assign dig      = SLOT_BITS'(key_x >> (lv_reg * SLOT_BITS));
    assign cur_addr = {node_reg, dig};
    assign leaf_lv  = (lv_reg == LW'(LEVELS - 1));
    assign busy     = (st_reg != ST_IDLE) || !clr_done_reg;
    assign done     = (st_reg == ST_DONE);
    assign old_value = rtm_pkg::OUT_VAL_W'(old_reg);
    assign no_room  = room_reg;
    assign push_node = node_reg;

    // sequencer
    always_comb begin
        st_next_s = st_reg;
        rd_addr   = cur_addr;
        wr_en = 1'b0; wr_addr = cur_addr; wr_data = '0;
        fill_we = 1'b0; fill_wa = node_reg; fill_wd = fill_rd;
        link_we = 1'b0; link_wa = fresh_reg; link_wd = cur_addr;
        fill_node = node_reg;
        sreq = '0;
        case (st_reg)
            ST_CLR: begin
                wr_en = 1'b1; wr_addr = clr_reg;
                fill_we = 1'b1; fill_wa = clr_reg[AW-1:SLOT_BITS]; fill_wd = '0;
                if (clr_reg == AW'(DEPTH - 1)) st_next_s = ST_IDLE;
            end
            ST_IDLE: if (start) st_next_s = ST_RD;
            ST_RD:   st_next_s = ST_WAIT;
            ST_WAIT: st_next_s = ST_CHK;
            ST_CHK: begin
                if (leaf_lv) begin
                    st_next_s = ST_LEAF;
                end else if (rd_data != '0) begin
                    st_next_s = ST_RD;
                end else if (alloc_reg) begin
                    st_next_s = ST_NEW;
                end else if (ins_reg) begin
                    st_next_s = (fcount >= CW'(LEVELS - 1) - CW'(lv_reg))
                              ? ST_NEW : ST_DONE;
                end else begin
                    st_next_s = ST_DONE;
                end
            end
            ST_NEW: begin
                // link fresh node into current slot
                sreq.pop = 1'b1;
                wr_en = 1'b1; wr_data = VALUE_BITS'(ftop);
                fill_we = 1'b1; fill_wd = fill_rd + FW'(1);
                st_next_s = ST_WIPE;
            end
            ST_WIPE: begin
                wr_en = 1'b1; wr_addr = {fresh_reg, wipe_reg};
                link_we = (wipe_reg == '0);
                fill_we = 1'b1; fill_wa = fresh_reg; fill_wd = '0;
                if (wipe_reg == {SLOT_BITS{1'b1}}) st_next_s = leaf_lv ? ST_LEAF : ST_RD;
            end
            ST_LEAF: begin
                if (ins_reg) begin
                    wr_en = 1'b1; wr_data = val_reg;
                    if (old_reg == '0) fill_wd = fill_rd + FW'(1);
                    fill_we = 1'b1;
                    st_next_s = ST_DONE;
                end else if (ers_reg && old_reg != '0) begin
                    wr_en = 1'b1;
                    fill_we = 1'b1;
                    if (fill_rd != '0) fill_wd = fill_rd - FW'(1);
                    st_next_s = (node_reg != '0 && fill_rd <= FW'(1)) ? ST_PLINK : ST_DONE;
                end else begin
                    st_next_s = ST_DONE;
                end
            end
            // parent link of node_reg lands in link_rd
            ST_PLINK: st_next_s = ST_PFILL;
            // fill count of the parent lands in fill_rd
            ST_PFILL: begin
                fill_node = link_rd[AW-1:SLOT_BITS];
                st_next_s = ST_PRUNE;
            end
            ST_PRUNE: begin
                // free node_reg, clear its parent slot
                sreq.push = (fcount < CW'(NODE_COUNT));
                wr_en = 1'b1; wr_addr = link_rd;
                fill_we = 1'b1; fill_wa = link_rd[AW-1:SLOT_BITS];
                fill_wd = (fill_rd != '0) ? fill_rd - FW'(1) : fill_rd;
                if (link_rd[AW-1:SLOT_BITS] == '0 || fill_rd > FW'(1))
                    st_next_s = ST_DONE;
                else
                    st_next_s = ST_PLINK;
            end
            ST_DONE: st_next_s = ST_IDLE;
            default: st_next_s = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLR;
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else begin
            st_reg <= st_next_s;
            if (st_reg == ST_CLR) clr_reg <= clr_reg + AW'(1);
            if (st_reg == ST_CLR && st_next_s == ST_IDLE) clr_done_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (st_reg)
            ST_IDLE: begin
                key_reg  <= KX'(key);
                val_reg  <= VALUE_BITS'(new_value);
                ins_reg  <= (kind == rtm_pkg::KIND_INSERT) && (VALUE_BITS'(new_value) != '0);
                ers_reg  <= (kind == rtm_pkg::KIND_ERASE)
                         || ((kind == rtm_pkg::KIND_INSERT) && (VALUE_BITS'(new_value) == '0));
                alloc_reg <= 1'b0;
                lv_reg   <= '0;
                node_reg <= '0;
                old_reg  <= '0;
                room_reg <= 1'b0;
            end
            ST_CHK: begin
                if (leaf_lv) begin
                    old_reg <= rd_data;
                end else if (rd_data != '0) begin
                    node_reg <= NW'(rd_data);
                    lv_reg   <= lv_reg + LW'(1);
                end else if (!alloc_reg && ins_reg) begin
                    room_reg  <= !(fcount >= CW'(LEVELS - 1) - CW'(lv_reg));
                    alloc_reg <= 1'b1;
                end
            end
            ST_NEW: begin
                fresh_reg <= ftop;
                wipe_reg  <= '0;
            end
            ST_WIPE: begin
                wipe_reg <= wipe_reg + SLOT_BITS'(1);
                if (wipe_reg == {SLOT_BITS{1'b1}}) begin
                    node_reg <= fresh_reg;
                    lv_reg   <= lv_reg + LW'(1);
                    if (leaf_lv) old_reg <= '0;
                end
            end
            ST_PRUNE: node_reg <= link_rd[AW-1:SLOT_BITS];
            default: ;
        endcase
    end

    // checks
    ap_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done held");
    ap_room_ins: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && no_room) |-> ins_reg) else $error("no_room on non-insert");
    ap_room_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && no_room) |-> old_value == '0) else $error("no_room with value");
    ap_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        fcount <= CW'(NODE_COUNT)) else $error("pool overflow");
endmodule

@@ rtl/core/radix_tree_map.sv @@
// Per level a lookup passes the read, wait and check states; an insert
// adds a link step and a wipe of every slot of each new node; an erase
// adds the parent-link, parent-fill and prune states per freed node.
// Only one request is in flight at a time; a held result blocks the input.
// Reset: a clearing pass over all NODE_COUNT<<SLOT_BITS slots zeroes the slot
// memory; s_tready stays low until it ends.
// ----------------------------------------------------------------------------
// radix_tree_map: sparse key-to-value map as a fixed-depth radix tree
// Stream wrapper around the walk engine with an output register.
// ----------------------------------------------------------------------------
module radix_tree_map #(
    parameter int LEVELS     = rtm_pkg::LEVELS_DEF,
    parameter int SLOT_BITS  = rtm_pkg::SLOT_BITS_DEF,
    parameter int NODE_COUNT = rtm_pkg::NODE_COUNT_DEF,
    parameter int VALUE_BITS = rtm_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // key[15:0], new_value[47:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // old_value[31:0]
    output logic        m_tuser    // no_room
);
    logic        busy, done, nr, pend_reg;
    logic [31:0] ov;
    logic        start;

    // accept only when the engine is idle and the output register is free or draining
    assign s_tready = !busy && !pend_reg && (!m_tvalid || m_tready);
    assign start    = s_tvalid && s_tready;

    rtm_engine #(.LEVELS(LEVELS), .SLOT_BITS(SLOT_BITS),
                 .NODE_COUNT(NODE_COUNT), .VALUE_BITS(VALUE_BITS)) u_eng (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .kind(s_tuser), .key(s_tdata[15:0]), .new_value(s_tdata[47:16]),
        .busy(busy), .done(done), .old_value(ov), .no_room(nr)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (start) pend_reg <= 1'b1;
            if (done) begin
                m_tvalid <= 1'b1;
                pend_reg <= 1'b0;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (done) begin
            m_tdata <= ov;
            m_tuser <= nr;
        end
    end
endmodule

@@ test/tb_radix_tree_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_tree_map: self-checking bench for the radix tree map
// Drives lookup/insert/erase requests with random idling and back pressure,
// predicts each result with a behavioral copy of the tree, and checks
// old_value and no_room for every result in order.
// ----------------------------------------------------------------------------
module tb_radix_tree_map;

    localparam int LV     = rtm_pkg::LEVELS_DEF;
    localparam int SB     = rtm_pkg::SLOT_BITS_DEF;
    localparam int NODES  = rtm_pkg::NODE_COUNT_DEF;
    localparam int SLOTS  = NODES << SB;
    localparam int DRAIN  = 200;

    typedef struct packed {
        logic [rtm_pkg::KIND_W-1:0]   kind;
        logic [rtm_pkg::KEY_W-1:0]    key;
        logic [rtm_pkg::IN_VAL_W-1:0] value;
    } map_req_t;

    typedef struct packed {
        logic [rtm_pkg::OUT_VAL_W-1:0] old_value;
        logic                          no_room;
    } map_rsp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    radix_tree_map u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // shadow tree state
    logic [31:0] tree_slot [SLOTS];
    logic [11:0] tree_link [NODES];
    int          tree_fill [NODES];
    int          free_stack [NODES];
    int          free_top;

    map_req_t pending_reqs [$];
    map_rsp_t expected_rsps [$];
    int       fail_count;
    bit       stim_done;
    bit       no_idle;
    int       hold_off;

    function automatic int digit(logic [15:0] key, int lv);
        return (key >> (lv * SB)) & ((1 << SB) - 1);
    endfunction

    function automatic int slot_ix(int node, int d);
        return ((node % NODES) << SB) | d;
    endfunction

    // returns leaf node or -1 when the path is missing
    function automatic int walk_path(logic [15:0] key);
        int node;
        node = 0;
        for (int lv = 0; lv < LV - 1; lv++) begin
            if (tree_slot[slot_ix(node, digit(key, lv))] == 0) return -1;
            node = tree_slot[slot_ix(node, digit(key, lv))] % NODES;
        end
        return node;
    endfunction

    function automatic logic [31:0] tree_erase(logic [15:0] key);
        int node, ix, parent;
        logic [31:0] old;
        node = walk_path(key);
        if (node < 0) return 0;
        ix = slot_ix(node, digit(key, LV - 1));
        old = tree_slot[ix];
        if (old == 0) return 0;
        tree_slot[ix] = 0;
        if (tree_fill[node] > 0) tree_fill[node]--;
        while (node != 0 && tree_fill[node] == 0) begin
            parent = (tree_link[node] >> SB) % NODES;
            tree_slot[slot_ix(parent, tree_link[node] & ((1 << SB) - 1))] = 0;
            if (tree_fill[parent] > 0) tree_fill[parent]--;
            if (free_top < NODES) free_stack[free_top++] = node;
            node = parent;
        end
        return old;
    endfunction

    function automatic map_rsp_t tree_apply(map_req_t r);
        map_rsp_t rsp;
        int node, needed, pa, fresh, leaf;
        rsp = '0;
        if (r.kind == rtm_pkg::KIND_INSERT && r.value != 0) begin
            node = 0;
            needed = 0;
            for (int lv = 0; lv < LV - 1; lv++) begin
                pa = slot_ix(node, digit(r.key, lv));
                if (tree_slot[pa] == 0) begin
                    needed = LV - 1 - lv;
                    break;
                end
                node = tree_slot[pa] % NODES;
            end
            if (needed > free_top) begin
                rsp.no_room = 1'b1;
                return rsp;
            end
            node = 0;
            for (int lv = 0; lv < LV - 1; lv++) begin
                pa = slot_ix(node, digit(r.key, lv));
                if (tree_slot[pa] == 0) begin
                    fresh = free_stack[--free_top] % NODES;
                    for (int s = 0; s < (1 << SB); s++) tree_slot[slot_ix(fresh, s)] = 0;
                    tree_fill[fresh] = 0;
                    tree_link[fresh] = 12'((node << SB) | digit(r.key, lv));
                    tree_slot[pa] = fresh;
                    tree_fill[node]++;
                end
                node = tree_slot[pa] % NODES;
            end
            pa = slot_ix(node, digit(r.key, LV - 1));
            rsp.old_value = tree_slot[pa];
            if (tree_slot[pa] == 0) tree_fill[node]++;
            tree_slot[pa] = r.value;
        end else if (r.kind == rtm_pkg::KIND_INSERT || r.kind == rtm_pkg::KIND_ERASE) begin
            rsp.old_value = tree_erase(r.key);
        end else begin
            leaf = walk_path(r.key);
            if (leaf >= 0) rsp.old_value = tree_slot[slot_ix(leaf, digit(r.key, LV - 1))];
        end
        return rsp;
    endfunction

    function automatic map_req_t mk_req(logic [1:0] kind, logic [15:0] key,
                                        logic [31:0] value);
        map_req_t r;
        r.kind = kind;
        r.key = key;
        r.value = value;
        return r;
    endfunction

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // limit
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 13)) begin
                map_req_t r;
                r = pending_reqs.pop_front();
                expected_rsps.push_back(tree_apply(r));
                s_tvalid <= 1'b1;
                s_tdata  <= {r.value, r.key};
                s_tuser  <= r.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected result old_value=%h no_room=%b", m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    map_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (m_tdata !== e.old_value) begin
                        $error("old_value expected %h actual %h", e.old_value, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== e.no_room) begin
                        $error("no_room expected %b actual %b", e.no_room, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idle || $urandom_range(99) >= 13;
            end
        end
    end

    // stimulus
    initial begin
        logic [15:0] base, k;
        int n, pick;
        logic [15:0] live_keys [$];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        fail_count = 0;
        stim_done = 0;
        no_idle = 0;
        hold_off = 0;
        for (int i = 0; i < SLOTS; i++) tree_slot[i] = 0;
        for (int i = 0; i < NODES; i++) begin
            tree_link[i] = 0;
            tree_fill[i] = 0;
        end
        for (int i = 0; i < NODES - 1; i++) free_stack[i] = NODES - 1 - i;
        free_top = NODES - 1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every kind, zero insert, missing paths, spare kind
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_LOOKUP, 16'h0000, 32'h0));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_ERASE, 16'hffff, 32'h0));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_INSERT, 16'h0000, 32'hffffffff));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_INSERT, 16'hffff, 32'h00000001));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_LOOKUP, 16'hffff, 32'h12345678));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_SPARE, 16'h0000, 32'h0));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_INSERT, 16'h0000, 32'h80000000));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_INSERT, 16'hffff, 32'h0));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_LOOKUP, 16'hffff, 32'h0));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_ERASE, 16'h0000, 32'hffffffff));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_ERASE, 16'h0000, 32'h0));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_INSERT, 16'h1234, 32'h0));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_INSERT, 16'h1234, 32'h5a5a5a5a));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_LOOKUP, 16'h1235, 32'h0));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_ERASE, 16'h1234, 32'h0));
        pending_reqs.push_back(mk_req(rtm_pkg::KIND_LOOKUP, 16'h1234, 32'h0));

        // pool exhaustion: past the sixteen root children, each distinct low
        // byte takes two fresh nodes, so 119 paths use 254 of the 255 nodes;
        // the rest overflow, then everything is freed again
        for (int i = 0; i < 130; i++)
            pending_reqs.push_back(mk_req(rtm_pkg::KIND_INSERT, 16'(i), $urandom | 32'h1));
        for (int i = 0; i < 130; i++)
            pending_reqs.push_back(mk_req(i % 2 ? rtm_pkg::KIND_ERASE : rtm_pkg::KIND_INSERT,
                                          16'(i), 32'h0));

        // long receiver stall while requests keep coming
        wait (pending_reqs.size() < 150);
        @(posedge aclk);
        hold_off = 400;

        // random: clustered keys so paths share nodes; some noise
        n = 0;
        while (n < 1272) begin
            if (pending_reqs.size() > 40) begin
                @(posedge aclk);
                continue;
            end
            if (n == 504) no_idle = 1;
            if (n == 800) no_idle = 0;
            base = $urandom & 16'hf0f0;
            for (int j = 0; j < 8; j++) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    k = $urandom;
                end else if (pick < 45 || live_keys.size() == 0) begin
                    k = base | ($urandom & 16'h0f0f);
                end else begin
                    k = live_keys[$urandom_range(live_keys.size() - 1)];
                end
                pick = $urandom_range(99);
                if (pick < 40) begin
                    pending_reqs.push_back(mk_req(rtm_pkg::KIND_INSERT, k,
                        $urandom_range(9) == 0 ? 32'h0 : $urandom));
                    live_keys.push_back(k);
                    if (live_keys.size() > 64) void'(live_keys.pop_front());
                end else if (pick < 65) begin
                    pending_reqs.push_back(mk_req(rtm_pkg::KIND_ERASE, k, $urandom));
                end else if (pick < 95) begin
                    pending_reqs.push_back(mk_req(rtm_pkg::KIND_LOOKUP, k, $urandom));
                end else begin
                    pending_reqs.push_back(mk_req(rtm_pkg::KIND_SPARE, k, $urandom));
                end
                n++;
            end
        end

        // drain
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_rsps.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        if (fail_count == 0 && expected_rsps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ radix_tree_map.f @@
rtl/core/rtm_pkg.sv
rtl/core/rtm_free_stack.sv
rtl/core/rtm_engine.sv
rtl/core/radix_tree_map.sv
test/tb_radix_tree_map.sv
